// ===== sv/tkss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared widths and control types for the top-k salient pixel selector.
// ----------------------------------------------------------------------------
package tkss_pkg;

  localparam int unsigned SAL_W       = 16;  // salience, unsigned Q0.16
  localparam int unsigned PIX_COORD_W = 10;  // row / column width on the ports
  localparam int unsigned CFG_K_W     = 7;   // k_count register width

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast pixel this cycle
    logic shift;  // move every entry one place toward the head
    logic clear;  // zero every entry
  } cell_ctrl_t;

endpackage

// ===== sv/tkss_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_pix_if
// Pixel input channel: valid / ready plus one pixel item.
// ----------------------------------------------------------------------------
interface tkss_pix_if;
  logic                             valid;
  logic                             ready;
  logic [tkss_pkg::SAL_W-1:0]       same_avg;
  logic [tkss_pkg::SAL_W-1:0]       diff_avg;
  logic [tkss_pkg::PIX_COORD_W-1:0] pixel_row;
  logic [tkss_pkg::PIX_COORD_W-1:0] pixel_col;
  logic                             last_pixel;

  modport source (
    output valid, same_avg, diff_avg, pixel_row, pixel_col, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, same_avg, diff_avg, pixel_row, pixel_col, last_pixel,
    output ready
  );
endinterface

// ===== sv/tkss_sel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_sel_if
// Result channel: valid / ready plus one selected pixel item.
// ----------------------------------------------------------------------------
interface tkss_sel_if;
  logic                             valid;
  logic                             ready;
  logic [tkss_pkg::PIX_COORD_W-1:0] out_row;
  logic [tkss_pkg::PIX_COORD_W-1:0] out_col;
  logic [tkss_pkg::SAL_W-1:0]       out_salience;
  logic                             last_result;

  modport source (
    output valid, out_row, out_col, out_salience, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, out_salience, last_result,
    output ready
  );
endinterface

// ===== sv/top_k_salient_pixel_select_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_salient_pixel_select_top
// Keeps the k most salient pixels of an image and streams them out in
// descending order of salience after the last pixel.
// ----------------------------------------------------------------------------
// The block takes one pixel item per cycle on pix_i while pix_i.ready is
// high; salience is |same_avg - diff_avg| in unsigned Q0.16. A chain of
// MAX_KEPT cells holds the list in descending order; every cell compares
// itself to the incoming pixel in the same cycle, so pixels stream back to
// back. A new pixel goes behind every entry of equal or greater salience,
// so an earlier pixel stays ahead of a later one of equal salience and a
// zero-salience pixel never enters. Once the pixel marked last_pixel is
// inserted, the chain drains toward its head: k result items leave on
// sel_o, one per cycle while sel_o.ready is high, the final one flagged by
// last_result; pix_i.ready stays low until the final item is taken, and
// the whole list is cleared with the final item. Unfilled entries come out
// as row 0, column 0, salience 0. k is the k_count register (reset 64),
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, which the block itself does not enforce. 0 acts as 1
// and values above MAX_KEPT act as MAX_KEPT.
// ----------------------------------------------------------------------------
module top_k_salient_pixel_select_top #(
  parameter int unsigned MAX_KEPT   = 64,  // list depth, 1..64
  parameter int unsigned COORD_BITS = 10   // stored bits per coordinate, 1..16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tkss_pkg::CFG_K_W-1:0] cfg_wdata_i,
  tkss_pix_if.sink                     pix_i,
  tkss_sel_if.source                   sel_o
);

  localparam int unsigned POS_W = 2 * COORD_BITS;

  tkss_pkg::cell_ctrl_t          ctrl;
  logic [tkss_pkg::CFG_K_W-1:0]  k_eff;
  logic                          out_last;
  logic [tkss_pkg::SAL_W-1:0]    new_sal;
  logic [POS_W-1:0]              new_pos;

  // Per-cell taps, with one extra slot per array for the chain boundary.
  logic [tkss_pkg::SAL_W-1:0]    sal_w  [MAX_KEPT+1];
  logic [POS_W-1:0]              pos_w  [MAX_KEPT+1];
  logic                          less_w [MAX_KEPT+1];

  tkss_ctrl #(
    .MAX_KEPT (MAX_KEPT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (pix_i.valid),
    .in_last_i   (pix_i.last_pixel),
    .out_ready_i (sel_o.ready),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (sel_o.valid),
    .out_last_o  (out_last),
    .k_eff_o     (k_eff),
    .ctrl_o      (ctrl)
  );

  // Salience: absolute difference, exact in 16 bits.
  assign new_sal = (pix_i.same_avg >= pix_i.diff_avg) ?
                   (pix_i.same_avg - pix_i.diff_avg) :
                   (pix_i.diff_avg - pix_i.same_avg);
  assign new_pos = {COORD_BITS'(pix_i.pixel_row), COORD_BITS'(pix_i.pixel_col)};

  // Head has no upper neighbor; the tail shifts in an empty entry.
  assign less_w[0]        = 1'b0;
  assign sal_w[MAX_KEPT]  = '0;
  assign pos_w[MAX_KEPT]  = '0;

  // Cell i reads sal_w / pos_w tap i+1 from its lower neighbor; tap i is its output.
  logic [tkss_pkg::SAL_W-1:0] cell_sal [MAX_KEPT];
  logic [POS_W-1:0]           cell_pos [MAX_KEPT];

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic active;
    assign active = (tkss_pkg::CFG_K_W'(i) < k_eff);

    tkss_cell #(
      .POS_W (POS_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .active_i    (active),
      .new_sal_i   (new_sal),
      .new_pos_i   (new_pos),
      .prev_less_i (less_w[i]),
      .prev_sal_i  ((i == 0) ? new_sal : cell_sal[(i == 0) ? 0 : i-1]),
      .prev_pos_i  ((i == 0) ? new_pos : cell_pos[(i == 0) ? 0 : i-1]),
      .next_sal_i  (sal_w[i+1]),
      .next_pos_i  (pos_w[i+1]),
      .less_o      (less_w[i+1]),
      .sal_o       (cell_sal[i]),
      .pos_o       (cell_pos[i])
    );

    // Drain path: cell i+1 feeds cell i on a shift.
    if (i > 0) begin : g_tap
      assign sal_w[i] = cell_sal[i];
      assign pos_w[i] = cell_pos[i];
    end
  end

  // The head tap is only read as the result; cell 0 never drains from above.
  assign sal_w[0] = cell_sal[0];
  assign pos_w[0] = cell_pos[0];

  // Results leave straight from the head cell register.
  assign sel_o.out_row      = tkss_pkg::PIX_COORD_W'(pos_w[0][POS_W-1:COORD_BITS]);
  assign sel_o.out_col      = tkss_pkg::PIX_COORD_W'(pos_w[0][COORD_BITS-1:0]);
  assign sel_o.out_salience = sal_w[0];
  assign sel_o.last_result  = out_last;

endmodule

// ===== sv/tkss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_cell
// One list entry: compares against the broadcast pixel and trades entries
// with its neighbors.
// ----------------------------------------------------------------------------
module tkss_cell #(
  parameter int unsigned POS_W = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tkss_pkg::cell_ctrl_t       ctrl_i,
  input  logic                       active_i,    // entry lies inside k
  input  logic [tkss_pkg::SAL_W-1:0] new_sal_i,
  input  logic [POS_W-1:0]           new_pos_i,
  input  logic                       prev_less_i, // upper neighbor gives way
  input  logic [tkss_pkg::SAL_W-1:0] prev_sal_i,
  input  logic [POS_W-1:0]           prev_pos_i,
  input  logic [tkss_pkg::SAL_W-1:0] next_sal_i,
  input  logic [POS_W-1:0]           next_pos_i,
  output logic                       less_o,
  output logic [tkss_pkg::SAL_W-1:0] sal_o,
  output logic [POS_W-1:0]           pos_o
);

  logic [tkss_pkg::SAL_W-1:0] sal_q, sal_d;
  logic [POS_W-1:0]           pos_q, pos_d;

  assign less_o = sal_q < new_sal_i;

  always_comb begin
    sal_d = sal_q;
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      sal_d = '0;
      pos_d = '0;
    end else if (ctrl_i.shift) begin
      sal_d = next_sal_i;
      pos_d = next_pos_i;
    end else if (ctrl_i.ins && active_i) begin
      if (prev_less_i) begin
        // new pixel lands above: push the upper entry down into this one
        sal_d = prev_sal_i;
        pos_d = prev_pos_i;
      end else if (less_o) begin
        sal_d = new_sal_i;
        pos_d = new_pos_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sal_q <= '0;
      pos_q <= '0;
    end else begin
      sal_q <= sal_d;
      pos_q <= pos_d;
    end
  end

  assign sal_o = sal_q;
  assign pos_o = pos_q;

endmodule

// ===== sv/tkss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_ctrl
// Sequencer: holds k_count, drives inserts into the chain and drains the
// list toward the head when the last pixel of an image has been inserted.
// ----------------------------------------------------------------------------
module tkss_ctrl #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tkss_pkg::CFG_K_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  input  logic                         out_ready_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output logic                         out_last_o,
  output logic [tkss_pkg::CFG_K_W-1:0] k_eff_o,
  output tkss_pkg::cell_ctrl_t         ctrl_o
);

  localparam logic [tkss_pkg::CFG_K_W-1:0] KMax = tkss_pkg::CFG_K_W'(MAX_KEPT);
  localparam logic [tkss_pkg::CFG_K_W-1:0] KOne = tkss_pkg::CFG_K_W'(1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e                        state_q;
  logic [tkss_pkg::CFG_K_W-1:0]  k_count_q;
  logic [tkss_pkg::CFG_K_W-1:0]  cnt_q;
  logic                          in_fire;
  logic                          out_fire;

  always_comb begin
    if (k_count_q == '0) begin
      k_eff_o = KOne;
    end else if (k_count_q > KMax) begin
      k_eff_o = KMax;
    end else begin
      k_eff_o = k_count_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_last_o  = (cnt_q == k_eff_o - KOne);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign ctrl_o.ins   = in_fire;
  assign ctrl_o.shift = out_fire;
  assign ctrl_o.clear = out_fire && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_count_q <= tkss_pkg::CFG_K_W'(64);
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        k_count_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire && in_last_i) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (out_last_o) begin
              state_q <= ST_IDLE;
              cnt_q   <= '0;
            end else begin
              cnt_q <= cnt_q + KOne;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/tkss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkss_checker
// Port-level checks on the top-k salient pixel selector.
// ----------------------------------------------------------------------------
module tkss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_last_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_last_i,
  input logic [tkss_pkg::SAL_W-1:0]       out_sal_i
);

  // Never take a pixel while the list drains.
  a_no_accept_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("pixel ready while results are pending");

  // The last pixel starts the drain on the next cycle.
  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i)
    else $error("no result after last pixel");

  // The final result ends the drain.
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("results continue after final item");

  // Results leave in non-increasing salience.
  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && (out_sal_i <= $past(out_sal_i))))
    else $error("salience rose within one list");

  // A stalled result stays valid and keeps its salience.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_sal_i)))
    else $error("stalled result changed");

endmodule

bind top_k_salient_pixel_select_top tkss_checker u_tkss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_last_i   (pix_i.last_pixel),
  .out_valid_i (sel_o.valid),
  .out_ready_i (sel_o.ready),
  .out_last_i  (sel_o.last_result),
  .out_sal_i   (sel_o.out_salience)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the top-k salient pixel selector.
// ----------------------------------------------------------------------------
// Pixel items enter through a short directed table and then through random
// images run under several idle and stall patterns. A shadow copy of the
// ranked list tracks every accepted pixel and queues the items that the
// block must emit on the last pixel. A monitor checks each selected item,
// field by field and in order, against that queue. Table rows whose outcome
// is obvious with k at one carry their expected item inline.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned LIST_DEPTH      = 64;   // MAX_KEPT of the instance
  localparam int unsigned COORD_W         = 10;   // COORD_BITS of the instance
  localparam int unsigned DRAIN_PAUSE     = 4;    // pause for a pending insert to settle
  localparam int unsigned LONG_HOLD       = 300;  // long receiver back-pressure
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 48;

  localparam logic [tkss_pkg::CFG_K_W-1:0] K_RESET = 7'd64;
  localparam logic [tkss_pkg::CFG_K_W-1:0] K_ZERO  = 7'd0;
  localparam logic [tkss_pkg::CFG_K_W-1:0] K_ONE   = 7'd1;
  localparam logic [tkss_pkg::CFG_K_W-1:0] K_MAX   = 7'd127;

  typedef struct packed {
    logic [tkss_pkg::SAL_W-1:0]       same_avg;
    logic [tkss_pkg::SAL_W-1:0]       diff_avg;
    logic [tkss_pkg::PIX_COORD_W-1:0] row;
    logic [tkss_pkg::PIX_COORD_W-1:0] col;
    logic                             last;
  } pixel_t;

  typedef struct packed {
    logic [tkss_pkg::PIX_COORD_W-1:0] row;
    logic [tkss_pkg::PIX_COORD_W-1:0] col;
    logic [tkss_pkg::SAL_W-1:0]       salience;
    logic                             last;
  } pick_t;

  typedef struct packed {
    logic                             set_k;   // write k_count before this pixel
    logic [tkss_pkg::CFG_K_W-1:0]     k_val;
    pixel_t                           px;
    logic                             typed;   // expected item given inline (k is one)
    pick_t                            want;
  } step_t;

  // Directed table: extremes, ties, zero salience, k saturation, short
  // lists and a k change in the middle of an image.
  localparam step_t DIRECTED_STEPS [22] = '{
    // k at reset value: one pixel, the rest of the list comes out empty
    '{1'b0, K_ZERO, '{16'hFFFF, 16'h0000, 10'd1023, 10'd1023, 1'b1}, 1'b0, '0},
    // k = 1: maximal salience at the origin
    '{1'b1, K_ONE,  '{16'h0000, 16'hFFFF, 10'd0, 10'd0, 1'b1}, 1'b1,
      '{10'd0, 10'd0, 16'hFFFF, 1'b1}},
    // zero salience never enters
    '{1'b0, K_ZERO, '{16'd1234, 16'd1234, 10'd5, 10'd7, 1'b1}, 1'b1,
      '{10'd0, 10'd0, 16'd0, 1'b1}},
    // equal salience: the earlier pixel stays ahead
    '{1'b0, K_ZERO, '{16'd100, 16'd40, 10'd1, 10'd2, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd40, 16'd100, 10'd3, 10'd4, 1'b1}, 1'b1,
      '{10'd1, 10'd2, 16'd60, 1'b1}},
    // strictly larger later pixel takes the head
    '{1'b0, K_ZERO, '{16'd10, 16'd0, 10'd9, 10'd9, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd0, 16'd11, 10'd8, 10'd8, 1'b1}, 1'b1,
      '{10'd8, 10'd8, 16'd11, 1'b1}},
    // k = 0 acts as one
    '{1'b1, K_ZERO, '{16'h8000, 16'h7FFF, 10'h2AA, 10'h155, 1'b1}, 1'b1,
      '{10'h2AA, 10'h155, 16'd1, 1'b1}},
    // k above the list depth saturates
    '{1'b1, K_MAX,  '{16'h5555, 16'hAAAA, 10'h155, 10'h2AA, 1'b1}, 1'b0, '0},
    // k = 4: ranking with a tie, a zero and a dropped tail
    '{1'b1, 7'd4,   '{16'd300, 16'd0, 10'd10, 10'd10, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd0, 16'd500, 10'd11, 10'd11, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd1300, 16'd1000, 10'd12, 10'd12, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd77, 16'd77, 10'd13, 10'd13, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd400, 16'd0, 10'd14, 10'd14, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd0, 16'd200, 10'd15, 10'd15, 1'b1}, 1'b0, '0},
    // fewer salient pixels than k
    '{1'b1, 7'd3,   '{16'd9, 16'd1, 10'd16, 10'd16, 1'b1}, 1'b0, '0},
    // k shrinks from four to two in the middle of an image
    '{1'b1, 7'd4,   '{16'd10, 16'd0, 10'd20, 10'd20, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd20, 16'd0, 10'd21, 10'd21, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd30, 16'd0, 10'd22, 10'd22, 1'b0}, 1'b0, '0},
    '{1'b0, K_ZERO, '{16'd40, 16'd0, 10'd23, 10'd23, 1'b0}, 1'b0, '0},
    '{1'b1, 7'd2,   '{16'd25, 16'd0, 10'd24, 10'd24, 1'b1}, 1'b0, '0},
    // back to four: the hidden entries must have been cleared as well
    '{1'b1, 7'd4,   '{16'd0, 16'd1, 10'd25, 10'd25, 1'b1}, 1'b0, '0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tkss_pkg::CFG_K_W-1:0]  cfg_wdata_i;

  tkss_pix_if pix_if ();
  tkss_sel_if sel_if ();

  top_k_salient_pixel_select_top #(
    .MAX_KEPT   (LIST_DEPTH),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .sel_o       (sel_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the ranked list and of k_count.
  logic [tkss_pkg::SAL_W-1:0]   kept_sal [LIST_DEPTH];
  logic [2*COORD_W-1:0]         kept_pos [LIST_DEPTH];
  logic [tkss_pkg::CFG_K_W-1:0] k_shadow;

  // Selected items still owed by the block, oldest first.
  pick_t       picks_due [$];
  int unsigned err_cnt = 0;

  // Idle and stall pressure, in percent; hold_left forces a long stall.
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;

  function automatic int unsigned active_k();
    if (k_shadow == 0) return 1;
    if (k_shadow > LIST_DEPTH) return LIST_DEPTH;
    return k_shadow;
  endfunction

  function automatic void clear_list();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      kept_sal[i] = '0;
      kept_pos[i] = '0;
    end
  endfunction

  // Insert one pixel behind every entry of equal or greater salience and
  // hand back the items it releases when it closes the image.
  function automatic void rank_pixel(input pixel_t px, output pick_t released[$]);
    int unsigned                k;
    int unsigned                slot;
    logic [tkss_pkg::SAL_W-1:0] sal;
    logic [tkss_pkg::SAL_W-1:0] tmp_sal;
    logic [2*COORD_W-1:0]       pos;
    logic [2*COORD_W-1:0]       tmp_pos;
    pick_t                      pick;
    released = {};
    k = active_k();
    sal = (px.same_avg >= px.diff_avg) ? px.same_avg - px.diff_avg
                                       : px.diff_avg - px.same_avg;
    pos = {px.row[COORD_W-1:0], px.col[COORD_W-1:0]};
    slot = k;
    while (slot > 0 && kept_sal[slot-1] < sal) slot--;
    for (int i = slot; i < k; i++) begin
      tmp_sal     = kept_sal[i];
      tmp_pos     = kept_pos[i];
      kept_sal[i] = sal;
      kept_pos[i] = pos;
      sal         = tmp_sal;
      pos         = tmp_pos;
    end
    if (px.last) begin
      for (int i = 0; i < k; i++) begin
        pick.row      = kept_pos[i][2*COORD_W-1:COORD_W];
        pick.col      = kept_pos[i][COORD_W-1:0];
        pick.salience = kept_sal[i];
        pick.last     = (i == k - 1);
        released.push_back(pick);
      end
      clear_list();
    end
  endfunction

  // Offer one pixel item, with random idle cycles ahead of it, and record
  // what it owes once the block takes it. Valid stays high on return.
  task automatic send_pixel(input pixel_t px, input logic typed, input pick_t want);
    pick_t released [$];
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.same_avg   <= px.same_avg;
    pix_if.diff_avg   <= px.diff_avg;
    pix_if.pixel_row  <= px.row;
    pix_if.pixel_col  <= px.col;
    pix_if.last_pixel <= px.last;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    rank_pixel(px, released);
    if (typed) begin
      picks_due.push_back(want);
    end else begin
      foreach (released[i]) picks_due.push_back(released[i]);
    end
  endtask

  // Drop valid and hold until every owed item has come out.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
  endtask

  // Write k_count only with the block idle; a pixel without last may still
  // be settling when the queue runs empty, so pause for DRAIN_PAUSE first.
  task automatic write_k(input logic [tkss_pkg::CFG_K_W-1:0] k_val);
    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    k_shadow     = k_val;
  endtask

  function automatic logic [tkss_pkg::CFG_K_W-1:0] pick_k();
    case ($urandom_range(9)) inside
      0:       return K_ZERO;
      1:       return K_ONE;
      2:       return K_RESET;
      3:       return tkss_pkg::CFG_K_W'($urandom_range(65, 127));
      4, 5:    return tkss_pkg::CFG_K_W'($urandom_range(2, 8));
      default: return tkss_pkg::CFG_K_W'($urandom_range(2, 63));
    endcase
  endfunction

  // Mostly short images; now and then one long enough to overflow the list.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 15) return $urandom_range(1, 12);
    if (r < 19) return $urandom_range(13, 40);
    return $urandom_range(41, 90);
  endfunction

  function automatic pixel_t random_pixel(input logic last);
    pixel_t px;
    px.row  = tkss_pkg::PIX_COORD_W'($urandom_range(0, 1023));
    px.col  = tkss_pkg::PIX_COORD_W'($urandom_range(0, 1023));
    px.last = last;
    case ($urandom_range(9)) inside
      // small salience range, so ties are common
      5, 6: begin
        px.same_avg = tkss_pkg::SAL_W'($urandom_range(0, 65535 - 15));
        px.diff_avg = px.same_avg + tkss_pkg::SAL_W'($urandom_range(0, 15));
        if ($urandom_range(1)) {px.same_avg, px.diff_avg} = {px.diff_avg, px.same_avg};
      end
      7: begin
        px.same_avg = tkss_pkg::SAL_W'($urandom);
        px.diff_avg = px.same_avg;
      end
      8: begin
        px.same_avg = $urandom_range(1) ? '1 : '0;
        px.diff_avg = $urandom_range(1) ? '1 : '0;
      end
      default: begin
        px.same_avg = tkss_pkg::SAL_W'($urandom);
        px.diff_avg = tkss_pkg::SAL_W'($urandom);
      end
    endcase
    return px;
  endfunction

  // One random phase: images of random length under a given idle pattern.
  // With squeeze set, stall the receiver for a long stretch while pixels
  // keep coming, and later pause the sender until the list has drained.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input logic squeeze);
    int unsigned sent;
    int unsigned img;
    int unsigned len;
    pick_t       none;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    none = '0;
    sent = 0;
    img  = 0;
    while (sent < ITEMS_PER_PHASE) begin
      if (img == 0 || $urandom_range(1) == 1) write_k(pick_k());
      len = pick_len();
      if (squeeze && img == 1) hold_left = LONG_HOLD;
      if (squeeze && img == 3) wait_drained();
      for (int n = 1; n <= len; n++) send_pixel(random_pixel(n == len), 1'b0, none);
      sent += len;
      img++;
    end
  endtask

  // Receiver: random stalls, or a forced long hold counted here.
  initial begin
    sel_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        sel_if.ready <= 1'b0;
        hold_left--;
      end else begin
        sel_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Check every selected item against the oldest owed one.
  always @(posedge clk_i) begin
    pick_t due;
    if (sel_if.valid && sel_if.ready) begin
      if (picks_due.size() == 0) begin
        $error("unexpected item: row %0d col %0d salience %0d last %0d",
               sel_if.out_row, sel_if.out_col, sel_if.out_salience, sel_if.last_result);
        err_cnt++;
      end else begin
        due = picks_due.pop_front();
        if (sel_if.out_row !== due.row) begin
          $error("out_row: expected %0d, got %0d", due.row, sel_if.out_row);
          err_cnt++;
        end
        if (sel_if.out_col !== due.col) begin
          $error("out_col: expected %0d, got %0d", due.col, sel_if.out_col);
          err_cnt++;
        end
        if (sel_if.out_salience !== due.salience) begin
          $error("out_salience: expected %0d, got %0d", due.salience, sel_if.out_salience);
          err_cnt++;
        end
        if (sel_if.last_result !== due.last) begin
          $error("last_result: expected %0d, got %0d", due.last, sel_if.last_result);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (sel_if.valid && sel_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    pix_if.valid      = 1'b0;
    pix_if.same_avg   = '0;
    pix_if.diff_avg   = '0;
    pix_if.pixel_row  = '0;
    pix_if.pixel_col  = '0;
    pix_if.last_pixel = 1'b0;
    k_shadow          = K_RESET;
    clear_list();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling on either side.
    for (int s = 0; s < $size(DIRECTED_STEPS); s++) begin
      if (DIRECTED_STEPS[s].set_k) write_k(DIRECTED_STEPS[s].k_val);
      send_pixel(DIRECTED_STEPS[s].px, DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].want);
    end

    // Random images under each idle pattern.
    run_phase(0, 0, 1'b1);
    run_phase(71, 0, 1'b0);
    run_phase(0, 71, 1'b0);
    run_phase(27, 27, 1'b0);

    // Drain, then idle so any stray item can still show.
    wait_drained();
    repeat (2 * DRAIN_PAUSE) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
